>>> src/sdinit_pkg.sv
// Types and constants for the SD card bring-up sequencer.
// Used by sd_card_init_sequencer_top and its testbench; no other dependencies.
`timescale 1ns / 1ps

package sdinit_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CMD0   = 4'd1,
    PH_CMD8   = 4'd2,
    PH_CMD55  = 4'd3,
    PH_ACMD41 = 4'd4,
    PH_CMD58  = 4'd5,
    PH_CMD2   = 4'd6,
    PH_CMD3   = 4'd7,
    PH_CMD10  = 4'd8,
    PH_CMD9   = 4'd9,
    PH_CMD7   = 4'd10,
    PH_CMD16  = 4'd11
  } phase_t;

  // Operation codes of an input transaction
  localparam logic OP_START = 1'b0;
  localparam logic OP_DONE  = 1'b1;

  // Error codes
  localparam logic [3:0] ERR_OK       = 4'd0;
  localparam logic [3:0] ERR_IFCOND   = 4'd1;
  localparam logic [3:0] ERR_NOTSD    = 4'd2;
  localparam logic [3:0] ERR_APPCMD   = 4'd3;
  localparam logic [3:0] ERR_OPCOND   = 4'd4;
  localparam logic [3:0] ERR_TIMEOUT  = 4'd5;
  localparam logic [3:0] ERR_CSD      = 4'd6;
  localparam logic [3:0] ERR_SELECT   = 4'd7;
  localparam logic [3:0] ERR_BLOCKLEN = 4'd8;

  // Command indexes
  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_ALL_CID   = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA  = 6'd3;
  localparam logic [5:0] CMD_SELECT    = 6'd7;
  localparam logic [5:0] CMD_IF_COND   = 6'd8;
  localparam logic [5:0] CMD_GET_CSD   = 6'd9;
  localparam logic [5:0] CMD_GET_CID   = 6'd10;
  localparam logic [5:0] CMD_BLOCKLEN  = 6'd16;
  localparam logic [5:0] CMD_OP_COND   = 6'd41;
  localparam logic [5:0] CMD_APP       = 6'd55;
  localparam logic [5:0] CMD_READ_OCR  = 6'd58;

  // Response format codes
  localparam logic [2:0] FMT_R1 = 3'd1;
  localparam logic [2:0] FMT_R2 = 3'd2;
  localparam logic [2:0] FMT_R3 = 3'd3;
  localparam logic [2:0] FMT_R6 = 3'd6;

  localparam logic [31:0] ARG_IF_COND   = 32'h0000_01aa;
  localparam logic [7:0]  IF_COND_ECHO  = 8'haa;
  localparam logic [31:0] APP_CMD_RESP  = 32'h0000_0120;
  localparam logic [23:0] VOLT_MASK     = 24'hff8000;
  localparam logic [31:0] OCR_HCS       = 32'h4000_0000;
  localparam logic [15:0] RETRY_RESET   = 16'd1000;
  localparam logic [15:0] BLKARG_RESET  = 16'd512;

  // Register indexes on the configuration port
  localparam logic REG_RETRY_LIMIT = 1'b0;
  localparam logic REG_BLOCK_ARG   = 1'b1;

  typedef struct packed {
    logic        operation;
    logic        crc_error;
    logic [15:0] fifo_word0;
    logic [15:0] fifo_word1;
    logic [15:0] fifo_word2;
    logic [15:0] fifo_word3;
    logic [15:0] fifo_word4;
    logic [15:0] fifo_word5;
    logic [15:0] fifo_word6;
    logic [15:0] fifo_word7;
  } in_item_t;

  typedef struct packed {
    logic        issue_command;
    logic [5:0]  cmd_code;
    logic [31:0] cmd_arg;
    logic [2:0]  resp_type;
    logic        finished;
    logic [3:0]  error_code;
    logic [15:0] rca;
    logic [23:0] voltage_window;
    logic        high_capacity;
    logic [1:0]  csd_version;
    logic [15:0] blk_bytes;
    logic [36:0] card_capacity;
  } out_item_t;

endpackage

>>> src/sd_card_init_sequencer_top.sv
// SD card bring-up sequencer: command sequence, response checks, CSD decode.
// Depends on sdinit_pkg for the phase enum, codes and transaction structs.
`timescale 1ns / 1ps

// Each input transaction (start, or command done with its response halfwords)
// yields exactly one result transaction carrying the next command or the end
// status (neither for a completion while idle), plus the current card data. An
// item is registered in the input register on accept, decoded combinationally
// and moved to the result register when that is free or being taken; a new
// item can be taken every cycle while results are taken. While a result waits
// for out_ready the input register holds one more item and then the input
// stalls. Write the two configuration registers (retry limit at 0x0, CMD16
// argument at 0x4) only while no transaction is in flight.
module sd_card_init_sequencer_top
  import sdinit_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic [15:0] retry_limit;
  logic [15:0] block_length_arg;

  // Card state
  phase_t      phase, phase_next;
  logic [15:0] retry_count, retry_count_next;
  logic [23:0] voltages, voltages_next;
  logic [15:0] card_address, card_address_next;
  logic        capacity_flag, capacity_flag_next;
  logic [1:0]  csd_ver, csd_ver_next;
  logic [15:0] block_length, block_length_next;
  logic [36:0] capacity, capacity_next;

  // Input stage
  in_item_t    item;
  logic        item_valid;
  logic        xfer;
  out_item_t   res_next;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BLOCK_ARG) ? {16'd0, block_length_arg}
                                              : {16'd0, retry_limit};

  assign xfer     = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || xfer;

  // Response decode
  logic [31:0]  resp;
  logic [127:0] csd_raw, csd;
  logic [3:0]   bl_hi, bl_exp;
  logic [2:0]   mult;
  logic [12:0]  csize0_p1;
  logic [22:0]  csize1_p1;
  logic [4:0]   shamt;
  logic [36:0]  cap_v0, cap_v1;
  logic         ifcond_bad, notsd_bad, ocr_ok, card_ready, csd_bad, high_bits_set;
  logic [15:0]  retry_inc;

  always_comb begin
    resp    = {item.fifo_word0[7:0], item.fifo_word1, item.fifo_word2[7:0]};
    csd_raw = {item.fifo_word0, item.fifo_word1, item.fifo_word2, item.fifo_word3,
               item.fifo_word4, item.fifo_word5, item.fifo_word6, item.fifo_word7};
    // Long response arrives rotated by one byte
    csd     = {csd_raw[119:0], csd_raw[127:120]};
    bl_hi   = csd[83:80];
    bl_exp  = (bl_hi < 4'd9) ? csd[25:22] : bl_hi;
    mult    = csd[49:47];
    csize0_p1 = {1'b0, csd[73:62]} + 13'd1;
    csize1_p1 = {1'b0, csd[69:48]} + 23'd1;
    shamt   = 5'(bl_exp) + 5'(mult) + 5'd2;
    cap_v0  = {24'd0, csize0_p1} << shamt;
    cap_v1  = {4'd0, csize1_p1, 10'd0};
    ifcond_bad    = item.crc_error || (resp[31:12] != 20'd0);
    notsd_bad     = resp[7:0] != IF_COND_ECHO;
    ocr_ok        = (resp[23:0] & VOLT_MASK) == VOLT_MASK;
    card_ready    = resp[31];
    csd_bad       = csd[127];
    high_bits_set = resp[31:16] != 16'd0;
    retry_inc     = retry_count + 16'd1;
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (item.operation == OP_START) begin
      phase_next = PH_CMD0;
    end else begin
      unique case (phase)
        PH_CMD0:   phase_next = PH_CMD8;
        PH_CMD8: begin
          if (ifcond_bad || notsd_bad || retry_limit == 16'd0) phase_next = PH_IDLE;
          else phase_next = PH_CMD55;
        end
        PH_CMD55:  phase_next = (resp != APP_CMD_RESP) ? PH_IDLE : PH_ACMD41;
        PH_ACMD41: begin
          priority if (!ocr_ok) phase_next = PH_IDLE;
          else if (card_ready) phase_next = PH_CMD58;
          else if (retry_inc >= retry_limit) phase_next = PH_IDLE;
          else phase_next = PH_CMD55;
        end
        PH_CMD58:  phase_next = PH_CMD2;
        PH_CMD2:   phase_next = PH_CMD3;
        PH_CMD3:   phase_next = PH_CMD10;
        PH_CMD10:  phase_next = PH_CMD9;
        PH_CMD9:   phase_next = csd_bad ? PH_IDLE : PH_CMD7;
        PH_CMD7:   phase_next = high_bits_set ? PH_IDLE : PH_CMD16;
        default:   phase_next = PH_IDLE;
      endcase
    end
  end

  // Command, status and card state
  always_comb begin
    res_next           = '0;
    retry_count_next   = retry_count;
    voltages_next      = voltages;
    card_address_next  = card_address;
    capacity_flag_next = capacity_flag;
    csd_ver_next       = csd_ver;
    block_length_next  = block_length;
    capacity_next      = capacity;
    if (item.operation == OP_START) begin
      retry_count_next   = '0;
      voltages_next      = '0;
      card_address_next  = '0;
      capacity_flag_next = 1'b0;
      csd_ver_next       = '0;
      block_length_next  = '0;
      capacity_next      = '0;
      res_next.issue_command = 1'b1;
      res_next.cmd_code      = CMD_GO_IDLE;
      res_next.resp_type     = FMT_R1;
    end else begin
      unique case (phase)
        PH_CMD0: begin
          res_next.issue_command = 1'b1;
          res_next.cmd_code      = CMD_IF_COND;
          res_next.resp_type     = FMT_R1;
          res_next.cmd_arg       = ARG_IF_COND;
        end
        PH_CMD8: begin
          priority if (ifcond_bad) begin
            res_next.finished   = 1'b1;
            res_next.error_code = ERR_IFCOND;
          end else if (notsd_bad) begin
            res_next.finished   = 1'b1;
            res_next.error_code = ERR_NOTSD;
          end else begin
            voltages_next    = resp[8] ? VOLT_MASK : 24'd0;
            retry_count_next = '0;
            if (retry_limit == 16'd0) begin
              res_next.finished   = 1'b1;
              res_next.error_code = ERR_TIMEOUT;
            end else begin
              res_next.issue_command = 1'b1;
              res_next.cmd_code      = CMD_APP;
              res_next.resp_type     = FMT_R1;
            end
          end
        end
        PH_CMD55: begin
          if (resp != APP_CMD_RESP) begin
            res_next.finished   = 1'b1;
            res_next.error_code = ERR_APPCMD;
          end else begin
            res_next.issue_command = 1'b1;
            res_next.cmd_code      = CMD_OP_COND;
            res_next.resp_type     = FMT_R3;
            res_next.cmd_arg       = OCR_HCS | {8'd0, voltages};
          end
        end
        PH_ACMD41: begin
          priority if (!ocr_ok) begin
            res_next.finished   = 1'b1;
            res_next.error_code = ERR_OPCOND;
          end else if (card_ready) begin
            res_next.issue_command = 1'b1;
            res_next.cmd_code      = CMD_READ_OCR;
            res_next.resp_type     = FMT_R3;
          end else begin
            retry_count_next = retry_inc;
            if (retry_inc >= retry_limit) begin
              res_next.finished   = 1'b1;
              res_next.error_code = ERR_TIMEOUT;
            end else begin
              res_next.issue_command = 1'b1;
              res_next.cmd_code      = CMD_APP;
              res_next.resp_type     = FMT_R1;
            end
          end
        end
        PH_CMD58: begin
          voltages_next      = resp[23:0] & VOLT_MASK;
          capacity_flag_next = resp[30];
          res_next.issue_command = 1'b1;
          res_next.cmd_code      = CMD_ALL_CID;
          res_next.resp_type     = FMT_R2;
        end
        PH_CMD2: begin
          res_next.issue_command = 1'b1;
          res_next.cmd_code      = CMD_SEND_RCA;
          res_next.resp_type     = FMT_R6;
        end
        PH_CMD3: begin
          card_address_next      = resp[31:16];
          res_next.issue_command = 1'b1;
          res_next.cmd_code      = CMD_GET_CID;
          res_next.resp_type     = FMT_R2;
          res_next.cmd_arg       = {resp[31:16], 16'd0};
        end
        PH_CMD10: begin
          res_next.issue_command = 1'b1;
          res_next.cmd_code      = CMD_GET_CSD;
          res_next.resp_type     = FMT_R2;
          res_next.cmd_arg       = {card_address, 16'd0};
        end
        PH_CMD9: begin
          csd_ver_next = csd[127:126];
          if (csd_bad) begin
            res_next.finished   = 1'b1;
            res_next.error_code = ERR_CSD;
          end else begin
            block_length_next = 16'd1 << bl_exp;
            capacity_next     = csd[126] ? cap_v1 : cap_v0;
            res_next.issue_command = 1'b1;
            res_next.cmd_code      = CMD_SELECT;
            res_next.resp_type     = FMT_R1;
            res_next.cmd_arg       = {card_address, 16'd0};
          end
        end
        PH_CMD7: begin
          if (high_bits_set) begin
            res_next.finished   = 1'b1;
            res_next.error_code = ERR_SELECT;
          end else begin
            res_next.issue_command = 1'b1;
            res_next.cmd_code      = CMD_BLOCKLEN;
            res_next.resp_type     = FMT_R1;
            res_next.cmd_arg       = {16'd0, block_length_arg};
          end
        end
        PH_CMD16: begin
          res_next.finished   = 1'b1;
          res_next.error_code = high_bits_set ? ERR_BLOCKLEN : ERR_OK;
        end
        default: begin
          // Completion while idle: the result carries no command and no status
        end
      endcase
    end
    res_next.rca            = card_address_next;
    res_next.voltage_window = voltages_next;
    res_next.high_capacity  = capacity_flag_next;
    res_next.csd_version    = csd_ver_next;
    res_next.blk_bytes      = block_length_next;
    res_next.card_capacity  = capacity_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit      <= RETRY_RESET;
      block_length_arg <= BLKARG_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_BLOCK_ARG) block_length_arg <= pwdata[15:0];
      else retry_limit <= pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid    <= 1'b0;
      out_valid     <= 1'b0;
      phase         <= PH_IDLE;
      retry_count   <= '0;
      voltages      <= '0;
      card_address  <= '0;
      capacity_flag <= 1'b0;
      csd_ver       <= '0;
      block_length  <= '0;
      capacity      <= '0;
    end else begin
      if (in_valid && in_ready) begin
        item_valid <= 1'b1;
      end else if (xfer) begin
        item_valid <= 1'b0;
      end
      if (xfer) begin
        out_valid     <= 1'b1;
        phase         <= phase_next;
        retry_count   <= retry_count_next;
        voltages      <= voltages_next;
        card_address  <= card_address_next;
        capacity_flag <= capacity_flag_next;
        csd_ver       <= csd_ver_next;
        block_length  <= block_length_next;
        capacity      <= capacity_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: load on transaction, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item <= in_item;
    if (xfer) out_item <= res_next;
  end

  a_end_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (xfer && res_next.finished) |=> (phase == PH_IDLE))
    else $error("phase not idle after a finishing result");

  a_fin_no_issue: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.finished && out_item.issue_command))
    else $error("result both issues a command and finishes");

  a_err_needs_fin: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.error_code != ERR_OK) |-> out_item.finished)
    else $error("error code without finish");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

>>> dv/tb_sd_card_init_sequencer_top.sv
// Self-checking testbench for sd_card_init_sequencer_top: bring-up sessions with
// random responses and faults, checked against a cycle-free model of the sequence.
// Depends on sdinit_pkg and the sequencer RTL only.
`timescale 1ns / 1ps

module tb_sd_card_init_sequencer_top;
  import sdinit_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 250;

  typedef enum int {
    F_NONE, F_IFCOND, F_NOTSD, F_APPCMD, F_OPCOND, F_CSD, F_SELECT, F_BLOCKLEN,
    F_ABORT, F_NOISE
  } fault_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sd_card_init_sequencer_top u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  in_item_t  host_events[$];
  out_item_t expected_replies[$];
  int        n_events = 0;
  int        n_replies = 0;
  int        errors = 0;
  int        cyc = 0;
  int        stall_cycles = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  int        cur_limit = RETRY_RESET;
  fault_t    sess_fault = F_NONE;
  int        sess_cut = 0;

  // Sequencer model state
  logic [15:0] m_retry_limit = RETRY_RESET;
  logic [15:0] m_blk_arg     = BLKARG_RESET;
  phase_t      m_phase       = PH_IDLE;
  logic [15:0] m_retry_cnt   = '0;
  logic [23:0] m_volt        = '0;
  logic [15:0] m_rca         = '0;
  logic        m_hcs         = 1'b0;
  logic [1:0]  m_ver         = '0;
  logic [15:0] m_blen        = '0;
  logic [36:0] m_size        = '0;

  function automatic out_item_t command(logic [5:0] idx, logic [2:0] fmt, logic [31:0] arg);
    out_item_t r;
    r = '0;
    r.issue_command = 1'b1;
    r.cmd_code = idx;
    r.resp_type = fmt;
    r.cmd_arg = arg;
    return r;
  endfunction

  function automatic out_item_t ending(logic [3:0] code);
    out_item_t r;
    r = '0;
    r.finished = 1'b1;
    r.error_code = code;
    return r;
  endfunction

  // Returns 1 when the CSD structure version is not supported.
  function automatic bit decode_csd(in_item_t it);
    logic [127:0] raw;
    logic [127:0] v;
    logic [3:0]   bl;
    logic [2:0]   mult;
    logic [63:0]  sz;
    raw = {it.fifo_word0, it.fifo_word1, it.fifo_word2, it.fifo_word3,
           it.fifo_word4, it.fifo_word5, it.fifo_word6, it.fifo_word7};
    v = {raw[119:0], raw[127:120]};
    m_ver = v[127:126];
    if (m_ver > 2'd1) return 1'b1;
    bl = v[83:80];
    if (bl < 4'd9) bl = v[25:22];
    m_blen = 16'd1 << bl;
    if (m_ver == 2'd0) begin
      mult = v[49:47];
      sz = (64'd1 << (bl + mult + 2)) * (64'(v[73:62]) + 64'd1);
    end else begin
      sz = (64'(v[69:48]) + 64'd1) * 64'd1024;
    end
    m_size = sz[36:0];
    return 1'b0;
  endfunction

  function automatic out_item_t sequence_reply(in_item_t it);
    out_item_t   r;
    logic [31:0] resp;
    logic [31:0] rca_arg;
    r = '0;
    resp = {it.fifo_word0[7:0], it.fifo_word1, it.fifo_word2[7:0]};
    rca_arg = {m_rca, 16'h0};
    if (it.operation == OP_START) begin
      m_retry_cnt = '0;
      m_volt = '0;
      m_rca = '0;
      m_hcs = 1'b0;
      m_ver = '0;
      m_blen = '0;
      m_size = '0;
      r = command(CMD_GO_IDLE, FMT_R1, 32'h0);
      m_phase = PH_CMD0;
    end else begin
      case (m_phase)
        PH_CMD0: begin
          r = command(CMD_IF_COND, FMT_R1, ARG_IF_COND);
          m_phase = PH_CMD8;
        end
        PH_CMD8: begin
          if (it.crc_error || resp[31:12] != '0) begin
            r = ending(ERR_IFCOND);
            m_phase = PH_IDLE;
          end else if (resp[7:0] != IF_COND_ECHO) begin
            r = ending(ERR_NOTSD);
            m_phase = PH_IDLE;
          end else begin
            m_volt = resp[8] ? VOLT_MASK : 24'h0;
            m_retry_cnt = '0;
            if (m_retry_limit == '0) begin
              r = ending(ERR_TIMEOUT);
              m_phase = PH_IDLE;
            end else begin
              r = command(CMD_APP, FMT_R1, 32'h0);
              m_phase = PH_CMD55;
            end
          end
        end
        PH_CMD55: begin
          if (resp != APP_CMD_RESP) begin
            r = ending(ERR_APPCMD);
            m_phase = PH_IDLE;
          end else begin
            r = command(CMD_OP_COND, FMT_R3, OCR_HCS | {8'h0, m_volt});
            m_phase = PH_ACMD41;
          end
        end
        PH_ACMD41: begin
          if ((resp[23:0] & VOLT_MASK) != VOLT_MASK) begin
            r = ending(ERR_OPCOND);
            m_phase = PH_IDLE;
          end else if (resp[31]) begin
            r = command(CMD_READ_OCR, FMT_R3, 32'h0);
            m_phase = PH_CMD58;
          end else begin
            m_retry_cnt = m_retry_cnt + 16'd1;
            if (m_retry_cnt >= m_retry_limit) begin
              r = ending(ERR_TIMEOUT);
              m_phase = PH_IDLE;
            end else begin
              r = command(CMD_APP, FMT_R1, 32'h0);
              m_phase = PH_CMD55;
            end
          end
        end
        PH_CMD58: begin
          m_volt = resp[23:0] & VOLT_MASK;
          m_hcs = resp[30];
          r = command(CMD_ALL_CID, FMT_R2, 32'h0);
          m_phase = PH_CMD2;
        end
        PH_CMD2: begin
          r = command(CMD_SEND_RCA, FMT_R6, 32'h0);
          m_phase = PH_CMD3;
        end
        PH_CMD3: begin
          m_rca = resp[31:16];
          r = command(CMD_GET_CID, FMT_R2, {m_rca, 16'h0});
          m_phase = PH_CMD10;
        end
        PH_CMD10: begin
          r = command(CMD_GET_CSD, FMT_R2, rca_arg);
          m_phase = PH_CMD9;
        end
        PH_CMD9: begin
          if (decode_csd(it)) begin
            r = ending(ERR_CSD);
            m_phase = PH_IDLE;
          end else begin
            r = command(CMD_SELECT, FMT_R1, rca_arg);
            m_phase = PH_CMD7;
          end
        end
        PH_CMD7: begin
          if (resp[31:16] != '0) begin
            r = ending(ERR_SELECT);
            m_phase = PH_IDLE;
          end else begin
            r = command(CMD_BLOCKLEN, FMT_R1, {16'h0, m_blk_arg});
            m_phase = PH_CMD16;
          end
        end
        PH_CMD16: begin
          r = ending(resp[31:16] != '0 ? ERR_BLOCKLEN : ERR_OK);
          m_phase = PH_IDLE;
        end
        default: m_phase = PH_IDLE;
      endcase
    end
    r.rca = m_rca;
    r.voltage_window = m_volt;
    r.high_capacity = m_hcs;
    r.csd_version = m_ver;
    r.blk_bytes = m_blen;
    r.card_capacity = m_size;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic in_item_t random_item();
    in_item_t it;
    it = {$urandom, $urandom, $urandom, $urandom, 2'($urandom)};
    return it;
  endfunction

  function automatic in_item_t random_done();
    in_item_t it;
    it = random_item();
    it.operation = OP_DONE;
    return it;
  endfunction

  function automatic in_item_t resp_item(logic [31:0] resp, logic crc);
    in_item_t it;
    it = random_done();
    it.crc_error = crc;
    it.fifo_word0 = {8'($urandom), resp[31:24]};
    it.fifo_word1 = resp[23:8];
    it.fifo_word2 = {8'($urandom), resp[7:0]};
    return it;
  endfunction

  // Pack a CSD value the way the FIFO delivers it: rotated right one byte.
  function automatic in_item_t csd_item(logic [127:0] v);
    in_item_t     it;
    logic [127:0] raw;
    raw = {v[7:0], v[127:8]};
    it = random_done();
    {it.fifo_word0, it.fifo_word1, it.fifo_word2, it.fifo_word3,
     it.fifo_word4, it.fifo_word5, it.fifo_word6, it.fifo_word7} = raw;
    return it;
  endfunction

  function automatic void add_event(in_item_t it);
    host_events.push_back(it);
    n_events++;
  endfunction

  // Returns 1 when the session is cut off after this step.
  function automatic bit push_step(in_item_t it, int idx);
    if (sess_fault == F_NOISE && idx == sess_cut) add_event(random_item());
    add_event(it);
    return sess_fault == F_ABORT && idx == sess_cut;
  endfunction

  task automatic queue_session(input int rounds, input fault_t fault);
    logic [31:0]  resp;
    logic [127:0] csd;
    in_item_t     it;
    bit           last;
    sess_fault = fault;
    sess_cut = $urandom_range(12, 2);
    it = random_item();
    it.operation = OP_START;
    add_event(it);
    if (push_step(random_done(), 2)) return;

    resp = {20'h0, 3'($urandom), 1'($urandom), IF_COND_ECHO};
    it = resp_item(resp, 1'b0);
    if (fault == F_IFCOND) begin
      if ($urandom_range(1)) it.crc_error = 1'b1;
      else it = resp_item(resp | (32'h1000 << $urandom_range(19)), 1'b0);
    end else if (fault == F_NOTSD) begin
      resp[7:0] = IF_COND_ECHO ^ 8'($urandom_range(255, 1));
      it = resp_item(resp, 1'b0);
    end
    if (push_step(it, 3) || fault == F_IFCOND || fault == F_NOTSD) return;
    if (cur_limit == 0) return;

    for (int r = 0; r <= rounds; r++) begin
      last = (r == rounds);
      resp = APP_CMD_RESP;
      if (fault == F_APPCMD && last) resp = resp ^ (32'h1 << $urandom_range(31));
      if (push_step(resp_item(resp, 1'($urandom)), 4) || (fault == F_APPCMD && last)) return;
      resp = $urandom;
      resp[23:15] = 9'h1ff;
      resp[31] = last;
      if (fault == F_OPCOND && last) resp[15 + $urandom_range(8)] = 1'b0;
      if (push_step(resp_item(resp, 1'($urandom)), 5) || (fault == F_OPCOND && last)) return;
      // not-ready round count reaches the limit: the sequence has timed out
      if (!last && r + 1 >= cur_limit) return;
    end

    if (push_step(resp_item($urandom, 1'($urandom)), 6)) return;
    if (push_step(random_done(), 7)) return;
    if (push_step(resp_item($urandom, 1'($urandom)), 8)) return;
    if (push_step(random_done(), 9)) return;

    csd = {$urandom, $urandom, $urandom, $urandom};
    csd[127:126] = (fault == F_CSD) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(1));
    if (push_step(csd_item(csd), 10) || fault == F_CSD) return;

    resp = {16'h0, 16'($urandom)};
    if (fault == F_SELECT) resp[31:16] = 16'($urandom_range(16'hffff, 1));
    if (push_step(resp_item(resp, 1'($urandom)), 11) || fault == F_SELECT) return;

    resp = {16'h0, 16'($urandom)};
    if (fault == F_BLOCKLEN) resp[31:16] = 16'($urandom_range(16'hffff, 1));
    void'(push_step(resp_item(resp, 1'($urandom)), 12));
  endtask

  task automatic reg_write(input logic idx, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_RETRY_LIMIT) begin
      m_retry_limit = data[15:0];
      cur_limit = data[15:0];
    end else begin
      m_blk_arg = data[15:0];
    end
  endtask

  task automatic drain();
    while (host_events.size() != 0 || in_valid || expected_replies.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] limit, input logic [15:0] blk);
    drain();
    reg_write(REG_RETRY_LIMIT, {16'h0, limit});
    reg_write(REG_BLOCK_ARG, {16'h0, blk});
    @(negedge clk);
  endtask

  function automatic bit take_gap();
    if (cyc >= 800 && cyc < 1400) return 1'b0;
    return $urandom_range(99) < 21;
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_replies.push_back(sequence_reply(in_item));
      if (host_events.size() != 0 && !take_gap()) begin
        in_valid <= 1'b1;
        in_item <= host_events.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_reply(input out_item_t got);
    out_item_t want;
    if (expected_replies.size() == 0) begin
      $display("%0t: unexpected result transaction, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = expected_replies.pop_front();
    check_field("issue_command", want.issue_command, got.issue_command);
    check_field("cmd_code", want.cmd_code, got.cmd_code);
    check_field("cmd_arg", want.cmd_arg, got.cmd_arg);
    check_field("resp_type", want.resp_type, got.resp_type);
    check_field("finished", want.finished, got.finished);
    check_field("error_code", want.error_code, got.error_code);
    check_field("rca", want.rca, got.rca);
    check_field("voltage_window", want.voltage_window, got.voltage_window);
    check_field("high_capacity", want.high_capacity, got.high_capacity);
    check_field("csd_version", want.csd_version, got.csd_version);
    check_field("blk_bytes", want.blk_bytes, got.blk_bytes);
    check_field("card_capacity", want.card_capacity, got.card_capacity);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_reply(out_item);
        n_replies++;
      end
      // hold off once for a long stretch so the input side backs up
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && n_replies >= 300) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !take_gap();
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (host_events.size() == 0 && !in_valid && expected_replies.size() == 0))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog: no transaction for %0d cycles", $time, stall_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------- test sequence

  initial begin
    in_item_t it;
    int       target;
    fault_t   fault;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: completions while idle, a clean bring-up, then a zero retry limit
    it = '1;
    it.operation = OP_DONE;
    add_event(it);
    it = '0;
    it.operation = OP_DONE;
    add_event(it);
    queue_session(1, F_NONE);
    configure(16'd0, 16'hffff);
    it = '1;
    it.operation = OP_START;
    add_event(it);
    add_event(random_done());
    add_event(resp_item({20'h0, 4'h1, IF_COND_ECHO}, 1'b0));
    queue_session(0, F_NONE);

    // Random sessions over several register settings
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: configure(16'd1, 16'd1);
        1: configure(16'hffff, 16'hffff);
        2: configure(16'd2, 16'($urandom));
        3: configure(16'($urandom_range(6, 1)), 16'($urandom_range(16'hffff, 1)));
        default: configure(RETRY_RESET, BLKARG_RESET);
      endcase
      target = n_events + 260;
      while (n_events < target) begin
        fault = ($urandom_range(1) != 0) ? F_NONE : fault_t'($urandom_range(F_NOISE, F_IFCOND));
        queue_session(($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(3), fault);
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(3, 1)) add_event(random_item());
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
